// ===== hdl/aws_pkg.sv =====
// Shared constants and controller/datapath signal groups for adc_window_statistics.
// No dependencies; compile first.
package aws_pkg;

    localparam int CODE_BITS_DEF  = 12;
    localparam int COUNT_BITS_DEF = 16;
    localparam int RAW_BITS       = 16;
    localparam int CFG_BITS       = 16;
    localparam int CODE_SHIFT     = 2;
    localparam int MEAN_FRAC      = 8;
    localparam int SQ_FRAC        = 2 * MEAN_FRAC;

    localparam logic [CFG_BITS-1:0] SAMPLE_COUNT_RESET = 16'd5000;

    typedef struct packed {
        logic acc;
        logic load_mean_div;
        logic div_step;
        logic load_sq_div;
        logic mul;
        logic load_sqrt;
        logic sqrt_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/aws_if.sv =====
// Valid/ready channel interfaces for raw ADC frames and window statistics.
// Depends on aws_pkg.
interface aws_in_if;
    logic                          valid;
    logic                          ready;
    logic [aws_pkg::RAW_BITS-1:0]  raw_frame;

    modport source (output valid, output raw_frame, input ready);
    modport sink   (input valid, input raw_frame, output ready);
endinterface

interface aws_out_if #(
    parameter int CODE_BITS = aws_pkg::CODE_BITS_DEF
);
    localparam int MW  = CODE_BITS + aws_pkg::MEAN_FRAC;
    localparam int SDW = CODE_BITS + aws_pkg::MEAN_FRAC - 1;

    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] min_code;
    logic [CODE_BITS-1:0] max_code;
    logic [CODE_BITS-1:0] span_code;
    logic [MW-1:0]        mean_q8;
    logic [SDW-1:0]       std_dev_q8;

    modport source (output valid, output min_code, output max_code, output span_code,
                     output mean_q8, output std_dev_q8, input ready);
    modport sink   (input valid, input min_code, input max_code, input span_code,
                    input mean_q8, input std_dev_q8, output ready);
endinterface

// ===== hdl/aws_datapath.sv =====
// Datapath: window accumulators, shared bit-serial divider, square unit,
// bit-serial integer square root and result register. Depends on aws_pkg, aws_if.
module aws_datapath #(
    parameter int CODE_BITS  = aws_pkg::CODE_BITS_DEF,
    parameter int COUNT_BITS = aws_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [aws_pkg::CFG_BITS-1:0]  i_cfg_wr_data,
    input  logic [aws_pkg::RAW_BITS-1:0]  i_raw_frame,
    input  aws_pkg::t_dp_cmd              i_cmd,
    output aws_pkg::t_dp_status           o_status,
    aws_out_if.source                     o_result
);
    localparam int SW  = CODE_BITS + COUNT_BITS;
    localparam int PW  = 2 * CODE_BITS;
    localparam int QW  = PW + COUNT_BITS;
    localparam int NW  = QW + aws_pkg::SQ_FRAC;
    localparam int MW  = CODE_BITS + aws_pkg::MEAN_FRAC;
    localparam int VW  = 2 * MW;
    localparam int RW  = MW;
    localparam int SDW = MW - 1;
    localparam int TW  = (COUNT_BITS > aws_pkg::CFG_BITS) ? COUNT_BITS : aws_pkg::CFG_BITS;
    localparam logic [TW-1:0] CountMax = TW'({COUNT_BITS{1'b1}});

    logic [aws_pkg::CFG_BITS-1:0] r_sample_count;
    logic [COUNT_BITS-1:0]        r_count;
    logic [CODE_BITS-1:0]         r_min;
    logic [CODE_BITS-1:0]         r_max;
    logic [SW-1:0]                r_sum;
    logic [QW-1:0]                r_sq_sum;

    logic [COUNT_BITS-1:0]        r_rem;
    logic [NW-1:0]                r_num;
    logic [MW-1:0]                r_mean;
    logic [VW-1:0]                r_msq;
    logic [VW-1:0]                r_mean_sq;
    logic [VW-1:0]                r_sq_val;
    logic [RW-1:0]                r_root;
    logic [RW+1:0]                r_srem;

    logic                         r_out_valid;
    logic [CODE_BITS-1:0]         r_o_min;
    logic [CODE_BITS-1:0]         r_o_max;
    logic [CODE_BITS-1:0]         r_o_span;
    logic [MW-1:0]                r_o_mean;
    logic [SDW-1:0]               r_o_sd;

    logic [CODE_BITS-1:0]         w_code;
    logic [PW-1:0]                w_code_sq;
    logic [COUNT_BITS-1:0]        w_count_inc;
    logic [TW-1:0]                w_sc_ext;
    logic [TW-1:0]                w_target;
    logic [COUNT_BITS:0]          w_div_shift;
    logic [COUNT_BITS:0]          w_div_diff;
    logic                         w_div_ge;
    logic [VW-1:0]                w_var;
    logic [RW+1:0]                w_sq_shift;
    logic [RW+1:0]                w_sq_trial;
    logic                         w_sq_ge;

    assign w_code      = CODE_BITS'(i_raw_frame >> aws_pkg::CODE_SHIFT);
    assign w_code_sq   = PW'(w_code) * PW'(w_code);
    assign w_count_inc = r_count + COUNT_BITS'(1);
    assign w_sc_ext    = TW'(r_sample_count);

    always_comb begin
        if (w_sc_ext == '0) begin
            w_target = TW'(1);
        end else if (w_sc_ext > CountMax) begin
            w_target = CountMax;
        end else begin
            w_target = w_sc_ext;
        end
    end

    assign w_div_shift = {r_rem, r_num[NW-1]};
    assign w_div_diff  = w_div_shift - {1'b0, r_count};
    assign w_div_ge    = (w_div_shift >= {1'b0, r_count});

    assign w_var       = (r_msq > r_mean_sq) ? (r_msq - r_mean_sq) : '0;

    assign w_sq_shift  = {r_srem[RW-1:0], r_sq_val[VW-1:VW-2]};
    assign w_sq_trial  = {r_root, 2'b01};
    assign w_sq_ge     = (w_sq_shift >= w_sq_trial);

    assign o_status.close    = (TW'(w_count_inc) >= w_target);
    assign o_status.out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= aws_pkg::SAMPLE_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_count  <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_sum    <= '0;
            r_sq_sum <= '0;
        end else if (i_cmd.acc) begin
            r_count  <= w_count_inc;
            r_sum    <= r_sum + SW'(w_code);
            r_sq_sum <= r_sq_sum + QW'(w_code_sq);
            if (w_code < r_min) begin
                r_min <= w_code;
            end
            if (w_code > r_max) begin
                r_max <= w_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mean_div) begin
            r_rem <= '0;
            r_num <= NW'({r_sum, {aws_pkg::MEAN_FRAC{1'b0}}});
        end else if (i_cmd.load_sq_div) begin
            r_rem  <= '0;
            r_num  <= {r_sq_sum, {aws_pkg::SQ_FRAC{1'b0}}};
            r_mean <= r_num[MW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_div_ge ? w_div_diff[COUNT_BITS-1:0] : w_div_shift[COUNT_BITS-1:0];
            r_num <= {r_num[NW-2:0], w_div_ge};
        end
        if (i_cmd.mul) begin
            r_msq     <= r_num[VW-1:0];
            r_mean_sq <= VW'(r_mean) * VW'(r_mean);
        end
        if (i_cmd.load_sqrt) begin
            r_sq_val <= w_var;
            r_root   <= '0;
            r_srem   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_val <= {r_sq_val[VW-3:0], 2'b00};
            r_srem   <= w_sq_ge ? (w_sq_shift - w_sq_trial) : w_sq_shift;
            r_root   <= {r_root[RW-2:0], w_sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_min  <= r_min;
            r_o_max  <= r_max;
            r_o_span <= r_max - r_min;
            r_o_mean <= r_mean;
            r_o_sd   <= r_root[SDW-1:0];
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.min_code   = r_o_min;
    assign o_result.max_code   = r_o_max;
    assign o_result.span_code  = r_o_span;
    assign o_result.mean_q8    = r_o_mean;
    assign o_result.std_dev_q8 = r_o_sd;

endmodule

// ===== hdl/aws_ctrl.sv =====
// Controller: sequences accumulation, the two divisions, squaring, square root
// and result hand-off. Depends on aws_pkg.
module aws_ctrl #(
    parameter int CODE_BITS  = aws_pkg::CODE_BITS_DEF,
    parameter int COUNT_BITS = aws_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  aws_pkg::t_dp_status  i_status,
    output aws_pkg::t_dp_cmd     o_cmd
);
    localparam int NW  = 2 * CODE_BITS + COUNT_BITS + aws_pkg::SQ_FRAC;
    localparam int RW  = CODE_BITS + aws_pkg::MEAN_FRAC;
    localparam int STW = $clog2(NW);

    localparam logic [3:0] ST_ACC      = 4'd0;
    localparam logic [3:0] ST_L_MEAN   = 4'd1;
    localparam logic [3:0] ST_DIV_MEAN = 4'd2;
    localparam logic [3:0] ST_L_SQ     = 4'd3;
    localparam logic [3:0] ST_DIV_SQ   = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_VAR      = 4'd6;
    localparam logic [3:0] ST_SQRT     = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    logic [STW-1:0] r_step;
    logic [STW-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_ACC: begin
                o_cmd.acc = i_in_valid;
                if (i_in_valid && i_status.close) begin
                    n_state = ST_L_MEAN;
                end
            end
            ST_L_MEAN: begin
                o_cmd.load_mean_div = 1'b1;
                n_step  = STW'(NW - 1);
                n_state = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step - STW'(1);
                if (r_step == '0) begin
                    n_state = ST_L_SQ;
                end
            end
            ST_L_SQ: begin
                o_cmd.load_sq_div = 1'b1;
                n_step  = STW'(NW - 1);
                n_state = ST_DIV_SQ;
            end
            ST_DIV_SQ: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step - STW'(1);
                if (r_step == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_VAR;
            end
            ST_VAR: begin
                o_cmd.load_sqrt = 1'b1;
                n_step  = STW'(RW - 1);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step - STW'(1);
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_ACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== hdl/adc_window_statistics.sv =====
// Top level of adc_window_statistics: controller plus datapath.
// Depends on aws_pkg, aws_if, aws_ctrl and aws_datapath.
//
// Every raw frame that is not the last of its window is taken when offered. The
// frame that closes a window starts the end-of-window computation, during which
// no frame is taken. That computation uses one shared restoring divider, one
// quotient bit per cycle, for the mean and the mean square, and a square-root
// unit that settles one root bit per cycle. Results sit in an output register,
// so the next window starts while a result waits; a further finished window
// waits only if that register is still full. A write to sample_count takes
// effect on the next frame.
module adc_window_statistics #(
    parameter int CODE_BITS  = aws_pkg::CODE_BITS_DEF,
    parameter int COUNT_BITS = aws_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [aws_pkg::CFG_BITS-1:0]  i_cfg_wr_data,
    aws_in_if.sink                        i_sample,
    aws_out_if.source                     o_result
);
    aws_pkg::t_dp_cmd    w_cmd;
    aws_pkg::t_dp_status w_status;

    aws_ctrl #(
        .CODE_BITS  (CODE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    aws_datapath #(
        .CODE_BITS  (CODE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_raw_frame   (i_sample.raw_frame),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_result      (o_result)
    );

    a_no_acc_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.acc && w_cmd.load_out))
        else $error("accumulate and result load in the same cycle");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_status.out_free)
        else $error("result loaded over an untaken transaction");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_result.valid)
        else $error("loaded result not presented");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.min_code <= o_result.max_code &&
                            o_result.span_code == o_result.max_code - o_result.min_code))
        else $error("result min/max/span inconsistent");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for adc_window_statistics: drives raw ADC frames,
// predicts the per-window min/max/span/mean/deviation and checks each result.
// Depends on aws_pkg, aws_if and the adc_window_statistics RTL.
module testbench;

    localparam int CODE_W      = aws_pkg::CODE_BITS_DEF;
    localparam int COUNT_W     = aws_pkg::COUNT_BITS_DEF;
    localparam int MEAN_W      = CODE_W + aws_pkg::MEAN_FRAC;
    localparam int SD_W        = CODE_W + aws_pkg::MEAN_FRAC - 1;
    localparam int DIV_CYCLES  = 2 * CODE_W + COUNT_W + 16;
    localparam int CALC_CYCLES = 2 * DIV_CYCLES + CODE_W + 8 + 5;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS_PER_MODE = 430;

    typedef struct packed {
        logic [CODE_W-1:0] min_code;
        logic [CODE_W-1:0] max_code;
        logic [CODE_W-1:0] span_code;
        logic [MEAN_W-1:0] mean_q8;
        logic [SD_W-1:0]   std_dev_q8;
    } t_window_stats;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [aws_pkg::CFG_BITS-1:0] cfg_wr_data;

    aws_in_if frame_if ();
    aws_out_if #(.CODE_BITS(CODE_W)) stats_if ();

    adc_window_statistics #(
        .CODE_BITS  (CODE_W),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_sample      (frame_if),
        .o_result      (stats_if)
    );

    logic [15:0]         frame_q[$];
    t_window_stats       window_stats_q[$];

    logic [15:0]         window_target;
    logic [COUNT_W-1:0]  window_count;
    logic [CODE_W-1:0]   window_min;
    logic [CODE_W-1:0]   window_max;
    logic [63:0]         window_sum;
    logic [63:0]         window_sq_sum;

    int send_idle_pct;
    int recv_idle_pct;
    int frames_taken;
    int windows_checked;
    int mismatches;
    int stall_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_window();
        window_count  = '0;
        window_min    = '1;
        window_max    = '0;
        window_sum    = '0;
        window_sq_sum = '0;
    endtask

    task automatic absorb_frame(input logic [15:0] raw);
        logic [CODE_W-1:0] code;
        logic [15:0]       goal;
        logic [63:0]       n;
        logic [63:0]       mean;
        logic [63:0]       mean_sq;
        logic [63:0]       var_q16;
        logic [63:0]       root;
        logic [63:0]       trial;
        t_window_stats     stats;
        code = raw[aws_pkg::CODE_SHIFT +: CODE_W];
        goal = (window_target == '0) ? 16'd1 : window_target;
        window_count = window_count + 1'b1;
        if (code < window_min) window_min = code;
        if (code > window_max) window_max = code;
        window_sum    = window_sum + 64'(code);
        window_sq_sum = window_sq_sum + 64'(code) * 64'(code);
        if (64'(window_count) >= 64'(goal)) begin
            n       = 64'(window_count);
            mean    = (window_sum << aws_pkg::MEAN_FRAC) / n;
            mean_sq = (window_sq_sum << aws_pkg::SQ_FRAC) / n;
            var_q16 = (mean_sq > mean * mean) ? mean_sq - mean * mean : 64'd0;
            root    = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= var_q16) root = trial;
            end
            stats.min_code   = window_min;
            stats.max_code   = window_max;
            stats.span_code  = window_max - window_min;
            stats.mean_q8    = mean[MEAN_W-1:0];
            stats.std_dev_q8 = root[SD_W-1:0];
            window_stats_q.push_back(stats);
            clear_window();
        end
    endtask

    // Mix of code extremes, a tight cluster and full-range noise; the outer bits stay random.
    function automatic logic [15:0] pick_frame(input logic [CODE_W-1:0] center);
        logic [15:0] f;
        int sel;
        f   = 16'($urandom);
        sel = $urandom_range(9);
        if (sel == 0)
            f[aws_pkg::CODE_SHIFT +: CODE_W] = '0;
        else if (sel == 1)
            f[aws_pkg::CODE_SHIFT +: CODE_W] = '1;
        else if (sel < 6)
            f[aws_pkg::CODE_SHIFT +: CODE_W] = center + CODE_W'($urandom_range(15)) - CODE_W'(8);
        return f;
    endfunction

    task automatic load_frames(input int count);
        logic [CODE_W-1:0] center;
        center = CODE_W'($urandom);
        @(negedge clk);
        repeat (count) frame_q.push_back(pick_frame(center));
    endtask

    task automatic settle();
        while (frame_q.size() != 0 || frame_if.valid || window_stats_q.size() != 0)
            @(negedge clk);
        repeat (CALC_CYCLES + 16) @(negedge clk);
    endtask

    task automatic write_sample_count(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        window_target  = value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            frame_if.valid     <= 1'b0;
            frame_if.raw_frame <= '0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                absorb_frame(frame_if.raw_frame);
                frames_taken++;
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    frame_if.valid     <= 1'b1;
                    frame_if.raw_frame <= frame_q.pop_front();
                end else begin
                    frame_if.valid     <= 1'b0;
                    frame_if.raw_frame <= 16'($urandom);
                end
            end
        end
    end

    always @(posedge clk) begin
        t_window_stats got;
        t_window_stats want;
        if (!rst_n) begin
            stats_if.ready <= 1'b0;
        end else begin
            if (stats_if.valid && stats_if.ready) begin
                got = {stats_if.min_code, stats_if.max_code, stats_if.span_code,
                       stats_if.mean_q8, stats_if.std_dev_q8};
                if (window_stats_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: min %0d max %0d span %0d mean %0d sd %0d",
                             $time, got.min_code, got.max_code, got.span_code,
                             got.mean_q8, got.std_dev_q8);
                end else begin
                    want = window_stats_q.pop_front();
                    windows_checked++;
                    if (got !== want) begin
                        mismatches++;
                        $display({"%0t: mismatch: expected min %0d max %0d span %0d mean %0d ",
                                  "sd %0d, actual min %0d max %0d span %0d mean %0d sd %0d"},
                                 $time, want.min_code, want.max_code, want.span_code,
                                 want.mean_q8, want.std_dev_q8, got.min_code, got.max_code,
                                 got.span_code, got.mean_q8, got.std_dev_q8);
                    end
                end
            end
            stats_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((frame_if.valid && frame_if.ready) || (stats_if.valid && stats_if.ready) ||
            (frame_q.size() == 0 && !frame_if.valid && window_stats_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, window_stats_q.size());
            $display("testbench: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [15:0] corner_frames [11];
        int pick;
        int tgt;
        int eff;
        int count;
        int planned;
        corner_frames = '{16'h0000, 16'hFFFF, 16'h0003, 16'hC000, 16'h3FFC, 16'hC003,
                          16'h0004, 16'h2000, 16'h1FFC, 16'h5555, 16'hAAAA};
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        frame_if.valid     = 1'b0;
        frame_if.raw_frame = '0;
        stats_if.ready     = 1'b0;
        send_idle_pct      = 32;
        recv_idle_pct      = 55;
        frames_taken       = 0;
        windows_checked    = 0;
        mismatches         = 0;
        stall_cycles       = 0;
        window_target      = aws_pkg::SAMPLE_COUNT_RESET;
        clear_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Partial window at the reset length; the shorter length written next closes it.
        @(negedge clk);
        foreach (corner_frames[i]) frame_q.push_back(corner_frames[i]);
        load_frames(40);
        settle();

        write_sample_count(16'd2);
        @(negedge clk);
        frame_q.push_back(16'h0000);
        frame_q.push_back(16'h3FFC);
        settle();
        write_sample_count(16'd0);
        @(negedge clk);
        frame_q.push_back(16'hFFFF);
        settle();
        write_sample_count(16'd1);
        @(negedge clk);
        frame_q.push_back(16'h0000);
        settle();
        write_sample_count(16'd40);
        @(negedge clk);
        repeat (5) frame_q.push_back(16'h1234);
        settle();
        // Shrink the window below the count already taken.
        write_sample_count(16'd3);
        @(negedge clk);
        frame_q.push_back(16'h8001);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 55 : 0;
            recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 32 : 0;
            planned = 0;
            while (planned < RANDOM_ITEMS_PER_MODE) begin
                settle();
                pick = $urandom_range(99);
                if (pick < 8)       tgt = 0;
                else if (pick < 16) tgt = 1;
                else if (pick < 56) tgt = $urandom_range(10, 2);
                else if (pick < 84) tgt = $urandom_range(100, 11);
                else if (pick < 92) tgt = $urandom_range(300, 200);
                else                tgt = $urandom_range(65535, 1000);
                write_sample_count(16'(tgt));
                eff = (tgt == 0) ? 1 : tgt;
                if (tgt >= 1000) begin
                    count = $urandom_range(20);
                end else begin
                    count = eff * ((eff <= 100) ? $urandom_range(3, 1) : 1);
                    if ($urandom_range(2) == 0) count += $urandom_range(eff - 1);
                end
                load_frames(count);
                planned += count;
            end
        end

        // Longest window length, codes mostly at full scale; a length of one then closes it.
        settle();
        write_sample_count(16'hFFFF);
        @(negedge clk);
        for (int i = 0; i < 100; i++)
            frame_q.push_back((i % 64 == 63) ? 16'($urandom) : 16'hFFFF);
        settle();
        write_sample_count(16'd1);
        @(negedge clk);
        frame_q.push_back(16'hFFFF);
        settle();

        $display("Covered %0d frames and %0d windows, lengths 0 to 65535, three idle mixes.",
                 frames_taken, windows_checked);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
